### hdl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// Frustum sphere cull package
// Shared types, codes and constant tables for the frustum culling block.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int unsigned PLANES = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned T_W    = 33;
  localparam int unsigned ROOT_W = 33;
  localparam int unsigned RAD_W  = 66;
  localparam int unsigned ACC_W  = 68;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_POINT  = 2'd1;
  localparam logic [1:0] MODE_SPHERE = 2'd2;

  localparam logic [3:0]  LAST_ENTRY   = 4'd15;
  localparam logic [30:0] MARGIN_RESET = 31'd524288;
  localparam logic [2:0]  LAST_PLANE   = 3'(PLANES - 1);
  localparam logic [4:0]  LAST_COEF    = 5'(PLANES * 4 - 1);

  // Row paired with row 3 for left, right, top, bottom and far; near uses row 2 alone.
  localparam logic [1:0] PAIR_ROW [PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [PLANES-1:0] USE_ROW3 = 6'b011111;
  localparam logic [PLANES-1:0] PAIR_NEG = 6'b010110;

  typedef enum logic [1:0] {
    OP_SQACC,
    OP_SQRT,
    OP_DIV
  } iter_op_e;

  typedef struct packed {
    logic     start;
    logic     clr;
    iter_op_e op;
  } iter_ctl_t;

  typedef struct packed {
    logic first;
    logic last;
  } dot_tag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST_RUN,
    ST_TEST_DRAIN,
    ST_RESULT,
    ST_RB_ROW3,
    ST_RB_PAIR,
    ST_RB_SQ_GO,
    ST_RB_SQ_WAIT,
    ST_RB_SQRT_GO,
    ST_RB_SQRT_WAIT,
    ST_RB_DIV_GO,
    ST_RB_DIV_WAIT
  } state_e;

endpackage

### hdl/fsc_iter_unit.sv
// ----------------------------------------------------------------------------
// Frustum sphere cull iterative unit
// Bit-serial square accumulate, square root and divide for the plane rebuild.
// ----------------------------------------------------------------------------
module fsc_iter_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fsc_pkg::iter_ctl_t                     ctl_i,
  input  logic [fsc_pkg::T_W-1:0]                mag_i,
  output logic [fsc_pkg::ROOT_W-1:0]             root_o,
  output logic [fsc_pkg::T_W+FRAC_BITS-1:0]      quo_o,
  output logic                                   done_o
);

  localparam int unsigned DIV_W = fsc_pkg::T_W + FRAC_BITS;
  localparam int unsigned REM_W = fsc_pkg::ROOT_W + 4;
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);
  localparam logic [CNT_W-1:0] SQ_STEPS   = CNT_W'(fsc_pkg::T_W);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(fsc_pkg::RAD_W / 2);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

  logic                        busy_q;
  logic                        done_q;
  fsc_pkg::iter_op_e           op_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [fsc_pkg::RAD_W-1:0]   acc_q;
  logic [fsc_pkg::RAD_W-1:0]   mcand_q;
  logic [fsc_pkg::T_W-1:0]     mplier_q;
  logic [fsc_pkg::ROOT_W-1:0]  root_q;
  logic [REM_W-1:0]            rem_q;
  logic [DIV_W-1:0]            quo_q;

  logic [fsc_pkg::RAD_W-1:0]   acc_sum;
  logic [REM_W-1:0]            sq_rem;
  logic [REM_W-1:0]            sq_trial;
  logic                        sq_ge;
  logic [REM_W-1:0]            dv_rem;
  logic [REM_W-1:0]            dv_div;
  logic                        dv_ge;

  assign acc_sum  = acc_q + (mplier_q[0] ? mcand_q : '0);
  assign sq_rem   = {rem_q[REM_W-3:0], acc_q[fsc_pkg::RAD_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;
  assign dv_rem   = {rem_q[REM_W-2:0], quo_q[DIV_W-1]};
  assign dv_div   = {4'b0000, root_q};
  assign dv_ge    = dv_rem >= dv_div;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= fsc_pkg::OP_SQACC;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      op_q   <= ctl_i.op;
      case (ctl_i.op)
        fsc_pkg::OP_SQRT: cnt_q <= SQRT_STEPS;
        fsc_pkg::OP_DIV:  cnt_q <= DIV_STEPS;
        default:          cnt_q <= SQ_STEPS;
      endcase
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_ONE;
      if (cnt_q == CNT_ONE) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      case (ctl_i.op)
        fsc_pkg::OP_SQACC: begin
          if (ctl_i.clr) begin
            acc_q <= '0;
          end
          mcand_q  <= {{(fsc_pkg::RAD_W - fsc_pkg::T_W){1'b0}}, mag_i};
          mplier_q <= mag_i;
        end
        fsc_pkg::OP_SQRT: begin
          rem_q  <= '0;
          root_q <= '0;
        end
        fsc_pkg::OP_DIV: begin
          rem_q <= '0;
          quo_q <= {mag_i, {FRAC_BITS{1'b0}}};
        end
        default: begin
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        fsc_pkg::OP_SQACC: begin
          acc_q    <= acc_sum;
          mcand_q  <= {mcand_q[fsc_pkg::RAD_W-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[fsc_pkg::T_W-1:1]};
        end
        fsc_pkg::OP_SQRT: begin
          rem_q  <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
          root_q <= {root_q[fsc_pkg::ROOT_W-2:0], sq_ge};
          acc_q  <= {acc_q[fsc_pkg::RAD_W-3:0], 2'b00};
        end
        fsc_pkg::OP_DIV: begin
          rem_q <= dv_ge ? (dv_rem - dv_div) : dv_rem;
          quo_q <= {quo_q[DIV_W-2:0], dv_ge};
        end
        default: begin
        end
      endcase
    end
  end

  assign root_o = root_q;
  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

### hdl/fsc_dot_mac.sv
// ----------------------------------------------------------------------------
// Frustum sphere cull dot product multiplier
// Registered signed 32 by 32 multiplier shared by all plane distance terms.
// ----------------------------------------------------------------------------
module fsc_dot_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  fsc_pkg::dot_tag_t   tag_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic                vld_o,
  output fsc_pkg::dot_tag_t   tag_o,
  output logic signed [63:0]  prod_o
);

  logic               vld_q;
  fsc_pkg::dot_tag_t  tag_q;
  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
      tag_q  <= tag_i;
    end
  end

  assign vld_o  = vld_q;
  assign tag_o  = tag_q;
  assign prod_o = prod_q;

endmodule

### hdl/frustum_sphere_cull_unit.sv
// ----------------------------------------------------------------------------
// Frustum sphere cull unit
// Rebuilds six normalized frustum planes from a loaded matrix and tests
// points and spheres against them.
// ----------------------------------------------------------------------------
// A point or sphere test raises its result word after the accept; the next
// word is accepted only once that result is registered, so tests do not overlap.
// A load writes its matrix entry; a load of entry 15 adds a plane rebuild, during
// which new words are stalled, in the bit-serial sqrt/divide unit.
// Reset clears the matrix and planes to zero and sets the margin to 8.0.
// ----------------------------------------------------------------------------
module frustum_sphere_cull_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic [30:0]        sphere_radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               inside_res_o
);

  localparam int unsigned DIV_W = fsc_pkg::T_W + FRAC_BITS;
  localparam int unsigned ACC_W = fsc_pkg::ACC_W;
  localparam logic signed [31:0] D_SCALE = 32'sd1 <<< FRAC_BITS;

  fsc_pkg::state_e state_q, state_d;

  logic [31:0]               matrix_q [16];
  logic [31:0]               plane_q [fsc_pkg::PLANES * 4];
  logic [30:0]               margin_q;
  logic signed [31:0]        cx_q, cy_q, cz_q;
  logic signed [ACC_W-1:0]   neg_lim_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      chk_q;
  logic                      rej_q;
  logic [4:0]                idx_q;
  logic signed [fsc_pkg::T_W-1:0] row3_q;
  logic signed [fsc_pkg::T_W-1:0] t_q [4];
  logic                      out_valid_q;
  logic                      inside_q;

  logic                      in_acc;
  logic                      out_free;
  logic [2:0]                pl;
  logic [1:0]                kk;
  logic                      last_plane;
  logic [3:0]                mat_addr;
  logic signed [fsc_pkg::T_W-1:0] mat_rd;
  logic signed [fsc_pkg::T_W-1:0] t_sel;
  logic [fsc_pkg::T_W-1:0]   mag;
  logic [30:0]               lim_sel;

  fsc_pkg::iter_ctl_t        ictl;
  logic [fsc_pkg::ROOT_W-1:0] root;
  logic [DIV_W-1:0]          quo;
  logic                      idone;
  logic                      root_zero;
  logic                      big_pos, big_neg;
  logic [31:0]               sat_val;

  logic                      mac_en;
  fsc_pkg::dot_tag_t         mac_tag, prod_tag;
  logic signed [31:0]        mac_b;
  logic                      prod_vld;
  logic signed [63:0]        prod;

  assign pl         = idx_q[4:2];
  assign kk         = idx_q[1:0];
  assign last_plane = pl == fsc_pkg::LAST_PLANE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign root_zero  = root == '0;
  assign cfg_ready_o = 1'b1;

  assign mat_addr = (state_q == fsc_pkg::ST_RB_ROW3) ? {kk, 2'b11}
                                                     : {kk, fsc_pkg::PAIR_ROW[pl]};
  assign mat_rd   = {matrix_q[mat_addr][31], matrix_q[mat_addr]};
  assign t_sel    = t_q[kk];
  assign mag      = t_sel[fsc_pkg::T_W-1] ? (~t_sel + 1'b1) : t_sel;
  assign lim_sel  = (mode_i == fsc_pkg::MODE_SPHERE) ? sphere_radius_i : margin_q;

  assign big_pos = |quo[DIV_W-1:31];
  assign big_neg = (|quo[DIV_W-1:32]) || (quo[31] && (|quo[30:0]));
  assign sat_val = t_sel[fsc_pkg::T_W-1]
                 ? (big_neg ? 32'h8000_0000 : (~quo[31:0] + 32'd1))
                 : (big_pos ? 32'h7FFF_FFFF : quo[31:0]);

  always_comb begin
    case (kk)
      2'd0:    mac_b = cx_q;
      2'd1:    mac_b = cy_q;
      2'd2:    mac_b = cz_q;
      default: mac_b = D_SCALE;
    endcase
  end

  fsc_iter_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ictl),
    .mag_i  (mag),
    .root_o (root),
    .quo_o  (quo),
    .done_o (idone)
  );

  fsc_dot_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mac_en),
    .tag_i  (mac_tag),
    .a_i    (plane_q[idx_q]),
    .b_i    (mac_b),
    .vld_o  (prod_vld),
    .tag_o  (prod_tag),
    .prod_o (prod)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (mode_i) inside
            fsc_pkg::MODE_LOAD: begin
              if (entry_index_i == fsc_pkg::LAST_ENTRY) begin
                state_d = fsc_pkg::ST_RB_ROW3;
              end
            end
            fsc_pkg::MODE_POINT, fsc_pkg::MODE_SPHERE: state_d = fsc_pkg::ST_TEST_RUN;
            default: state_d = fsc_pkg::ST_IDLE;
          endcase
        end
      end
      fsc_pkg::ST_TEST_RUN: begin
        if (idx_q == fsc_pkg::LAST_COEF) begin
          state_d = fsc_pkg::ST_TEST_DRAIN;
        end
      end
      fsc_pkg::ST_TEST_DRAIN: begin
        if (!prod_vld && !chk_q) begin
          state_d = fsc_pkg::ST_RESULT;
        end
      end
      fsc_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = fsc_pkg::ST_IDLE;
        end
      end
      fsc_pkg::ST_RB_ROW3: state_d = fsc_pkg::ST_RB_PAIR;
      fsc_pkg::ST_RB_PAIR: begin
        state_d = (kk == 2'd3) ? fsc_pkg::ST_RB_SQ_GO : fsc_pkg::ST_RB_ROW3;
      end
      fsc_pkg::ST_RB_SQ_GO: state_d = fsc_pkg::ST_RB_SQ_WAIT;
      fsc_pkg::ST_RB_SQ_WAIT: begin
        if (idone) begin
          state_d = (kk == 2'd2) ? fsc_pkg::ST_RB_SQRT_GO : fsc_pkg::ST_RB_SQ_GO;
        end
      end
      fsc_pkg::ST_RB_SQRT_GO: state_d = fsc_pkg::ST_RB_SQRT_WAIT;
      fsc_pkg::ST_RB_SQRT_WAIT: begin
        if (idone) begin
          if (!root_zero) begin
            state_d = fsc_pkg::ST_RB_DIV_GO;
          end else begin
            state_d = last_plane ? fsc_pkg::ST_IDLE : fsc_pkg::ST_RB_ROW3;
          end
        end
      end
      fsc_pkg::ST_RB_DIV_GO: state_d = fsc_pkg::ST_RB_DIV_WAIT;
      fsc_pkg::ST_RB_DIV_WAIT: begin
        if (idone) begin
          if (kk != 2'd3) begin
            state_d = fsc_pkg::ST_RB_DIV_GO;
          end else begin
            state_d = last_plane ? fsc_pkg::ST_IDLE : fsc_pkg::ST_RB_ROW3;
          end
        end
      end
      default: state_d = fsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = state_q != fsc_pkg::ST_IDLE;
    mac_en        = state_q == fsc_pkg::ST_TEST_RUN;
    mac_tag.first = kk == 2'd0;
    mac_tag.last  = kk == 2'd3;
    ictl.start    = 1'b0;
    ictl.clr      = kk == 2'd0;
    ictl.op       = fsc_pkg::OP_SQACC;
    unique case (state_q)
      fsc_pkg::ST_RB_SQ_GO: begin
        ictl.start = 1'b1;
      end
      fsc_pkg::ST_RB_SQRT_GO: begin
        ictl.start = 1'b1;
        ictl.op    = fsc_pkg::OP_SQRT;
      end
      fsc_pkg::ST_RB_DIV_GO: begin
        ictl.start = 1'b1;
        ictl.op    = fsc_pkg::OP_DIV;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsc_pkg::ST_IDLE;
      margin_q    <= fsc_pkg::MARGIN_RESET;
      out_valid_q <= 1'b0;
      chk_q       <= 1'b0;
      idx_q       <= '0;
      for (int i = 0; i < 16; i++) begin
        matrix_q[i] <= '0;
      end
      for (int i = 0; i < fsc_pkg::PLANES * 4; i++) begin
        plane_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      chk_q   <= prod_vld && prod_tag.last;
      if (cfg_valid_i) begin
        margin_q <= cfg_data_i;
      end
      if (state_q == fsc_pkg::ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        idx_q <= '0;
        if (mode_i == fsc_pkg::MODE_LOAD) begin
          matrix_q[entry_index_i] <= entry_value_i;
        end
      end
      unique case (state_q)
        fsc_pkg::ST_TEST_RUN: idx_q <= idx_q + 5'd1;
        fsc_pkg::ST_RB_PAIR:  idx_q <= {pl, kk + 2'd1};
        fsc_pkg::ST_RB_SQ_WAIT: begin
          if (idone) begin
            idx_q <= {pl, (kk == 2'd2) ? 2'd0 : kk + 2'd1};
          end
        end
        fsc_pkg::ST_RB_SQRT_WAIT: begin
          if (idone && root_zero) begin
            for (int j = 0; j < 4; j++) begin
              plane_q[{pl, 2'(j)}] <= '0;
            end
            idx_q <= {pl + 3'd1, 2'd0};
          end
        end
        fsc_pkg::ST_RB_DIV_WAIT: begin
          if (idone) begin
            plane_q[idx_q] <= sat_val;
            idx_q          <= idx_q + 5'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cx_q      <= center_x_i;
      cy_q      <= center_y_i;
      cz_q      <= center_z_i;
      neg_lim_q <= -($signed(ACC_W'(lim_sel) << FRAC_BITS));
      rej_q     <= 1'b0;
    end else if (chk_q && (acc_q < neg_lim_q)) begin
      rej_q <= 1'b1;
    end
    if (prod_vld) begin
      acc_q <= prod_tag.first ? ACC_W'(prod) : acc_q + ACC_W'(prod);
    end
    if (state_q == fsc_pkg::ST_RESULT && out_free) begin
      inside_q <= !rej_q;
    end
    if (state_q == fsc_pkg::ST_RB_ROW3) begin
      row3_q <= fsc_pkg::USE_ROW3[pl] ? mat_rd : '0;
    end
    if (state_q == fsc_pkg::ST_RB_PAIR) begin
      t_q[kk] <= fsc_pkg::PAIR_NEG[pl] ? (row3_q - mat_rd) : (row3_q + mat_rd);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule
